FILE: src/qvr_pkg.sv
// Shared definitions for the quaternion vector rotation unit.
// Holds the quaternion part and vector axis indices; no dependencies.
package qvr_pkg;

  localparam int NUM_PARTS = 4;
  localparam int NUM_AXES  = 3;

  typedef enum logic [1:0] {
    PART_W = 2'd0,
    PART_X = 2'd1,
    PART_Y = 2'd2,
    PART_Z = 2'd3
  } part_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

endpackage

FILE: src/qvr_if.sv
// Valid/ready channel interfaces of the quaternion vector rotation unit.
// The input channel carries a quaternion and a vector, the output channel a rotated vector.
// No package dependencies.
interface qvr_in_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] quat_w;
  logic signed [W-1:0] quat_x;
  logic signed [W-1:0] quat_y;
  logic signed [W-1:0] quat_z;
  logic signed [W-1:0] vec_x;
  logic signed [W-1:0] vec_y;
  logic signed [W-1:0] vec_z;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    input  ready
  );
  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    output ready
  );
endinterface

interface qvr_out_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] rot_x;
  logic signed [W-1:0] rot_y;
  logic signed [W-1:0] rot_z;
  logic                saturated;

  modport source (
    output valid, rot_x, rot_y, rot_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, rot_x, rot_y, rot_z, saturated,
    output ready
  );
endinterface

FILE: src/qvr_cross.sv
// First Hamilton product (0, v) * conj(q): twelve products, then their sums.
// Two pipeline stages with per-stage valid and ready; depends on qvr_pkg.
module qvr_cross #(
  parameter int W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic signed [W-1:0]   quat_i [qvr_pkg::NUM_PARTS],
  input  logic signed [W-1:0]   vec_i  [qvr_pkg::NUM_AXES],
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic signed [W-1:0]   quat_o [qvr_pkg::NUM_PARTS],
  output logic signed [2*W+1:0] part_o [qvr_pkg::NUM_PARTS]
);
  import qvr_pkg::*;

  localparam int PW = 2 * W;
  localparam int AW = 2 * W + 2;

  logic                s1_vld_q;
  logic                s1_rdy;
  logic signed [PW-1:0] prd_d [12];
  logic signed [PW-1:0] prd_q [12];
  logic signed [W-1:0]  quat1_q [NUM_PARTS];

  logic                s2_vld_q;
  logic                s2_rdy;
  logic signed [AW-1:0] part_d [NUM_PARTS];
  logic signed [AW-1:0] part_q [NUM_PARTS];
  logic signed [W-1:0]  quat2_q [NUM_PARTS];

  assign s2_rdy  = !s2_vld_q || ready_i;
  assign s1_rdy  = !s1_vld_q || s2_rdy;
  assign ready_o = s1_rdy;
  assign valid_o = s2_vld_q;
  assign quat_o  = quat2_q;
  assign part_o  = part_q;

  assign prd_d[0]  = quat_i[PART_X] * vec_i[AXIS_X];
  assign prd_d[1]  = quat_i[PART_Y] * vec_i[AXIS_Y];
  assign prd_d[2]  = quat_i[PART_Z] * vec_i[AXIS_Z];
  assign prd_d[3]  = quat_i[PART_W] * vec_i[AXIS_X];
  assign prd_d[4]  = quat_i[PART_Y] * vec_i[AXIS_Z];
  assign prd_d[5]  = quat_i[PART_Z] * vec_i[AXIS_Y];
  assign prd_d[6]  = quat_i[PART_W] * vec_i[AXIS_Y];
  assign prd_d[7]  = quat_i[PART_X] * vec_i[AXIS_Z];
  assign prd_d[8]  = quat_i[PART_Z] * vec_i[AXIS_X];
  assign prd_d[9]  = quat_i[PART_W] * vec_i[AXIS_Z];
  assign prd_d[10] = quat_i[PART_X] * vec_i[AXIS_Y];
  assign prd_d[11] = quat_i[PART_Y] * vec_i[AXIS_X];

  assign part_d[PART_W] = AW'(prd_q[0]) + AW'(prd_q[1]) + AW'(prd_q[2]);
  assign part_d[PART_X] = AW'(prd_q[3]) + AW'(prd_q[4]) - AW'(prd_q[5]);
  assign part_d[PART_Y] = AW'(prd_q[6]) - AW'(prd_q[7]) + AW'(prd_q[8]);
  assign part_d[PART_Z] = AW'(prd_q[9]) + AW'(prd_q[10]) - AW'(prd_q[11]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_vld_q <= valid_i;
      end
      if (s2_rdy) begin
        s2_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && valid_i) begin
      prd_q   <= prd_d;
      quat1_q <= quat_i;
    end
    if (s2_rdy && s1_vld_q) begin
      part_q  <= part_d;
      quat2_q <= quat1_q;
    end
  end

  // A zero quaternion must give a zero intermediate quaternion.
  a_zero_quat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && quat2_q[PART_W] == '0 && quat2_q[PART_X] == '0 &&
     quat2_q[PART_Y] == '0 && quat2_q[PART_Z] == '0) |->
    (part_q[PART_W] == '0 && part_q[PART_X] == '0 &&
     part_q[PART_Y] == '0 && part_q[PART_Z] == '0))
    else $error("zero quaternion gave a nonzero intermediate product");

endmodule

FILE: src/qvr_rotate.sv
// Second Hamilton product q * a, vector part only: twelve products, then their sums.
// Two pipeline stages with per-stage valid and ready; depends on qvr_pkg.
module qvr_rotate #(
  parameter int W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic signed [W-1:0]   quat_i [qvr_pkg::NUM_PARTS],
  input  logic signed [2*W+1:0] part_i [qvr_pkg::NUM_PARTS],
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic signed [3*W+3:0] rot_o  [qvr_pkg::NUM_AXES]
);
  import qvr_pkg::*;

  localparam int PW = 3 * W + 2;
  localparam int RW = 3 * W + 4;

  logic                 s3_vld_q;
  logic                 s3_rdy;
  logic signed [PW-1:0] prd_d [12];
  logic signed [PW-1:0] prd_q [12];

  logic                 s4_vld_q;
  logic                 s4_rdy;
  logic signed [RW-1:0] rot_d [NUM_AXES];
  logic signed [RW-1:0] rot_q [NUM_AXES];

  assign s4_rdy  = !s4_vld_q || ready_i;
  assign s3_rdy  = !s3_vld_q || s4_rdy;
  assign ready_o = s3_rdy;
  assign valid_o = s4_vld_q;
  assign rot_o   = rot_q;

  assign prd_d[0]  = part_i[PART_W] * quat_i[PART_X];
  assign prd_d[1]  = part_i[PART_X] * quat_i[PART_W];
  assign prd_d[2]  = part_i[PART_Y] * quat_i[PART_Z];
  assign prd_d[3]  = part_i[PART_Z] * quat_i[PART_Y];
  assign prd_d[4]  = part_i[PART_W] * quat_i[PART_Y];
  assign prd_d[5]  = part_i[PART_X] * quat_i[PART_Z];
  assign prd_d[6]  = part_i[PART_Y] * quat_i[PART_W];
  assign prd_d[7]  = part_i[PART_Z] * quat_i[PART_X];
  assign prd_d[8]  = part_i[PART_W] * quat_i[PART_Z];
  assign prd_d[9]  = part_i[PART_X] * quat_i[PART_Y];
  assign prd_d[10] = part_i[PART_Y] * quat_i[PART_X];
  assign prd_d[11] = part_i[PART_Z] * quat_i[PART_W];

  assign rot_d[AXIS_X] = RW'(prd_q[0]) + RW'(prd_q[1]) - RW'(prd_q[2]) + RW'(prd_q[3]);
  assign rot_d[AXIS_Y] = RW'(prd_q[4]) + RW'(prd_q[5]) + RW'(prd_q[6]) - RW'(prd_q[7]);
  assign rot_d[AXIS_Z] = RW'(prd_q[8]) - RW'(prd_q[9]) + RW'(prd_q[10]) + RW'(prd_q[11]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      if (s3_rdy) begin
        s3_vld_q <= valid_i;
      end
      if (s4_rdy) begin
        s4_vld_q <= s3_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy && valid_i) begin
      prd_q <= prd_d;
    end
    if (s4_rdy && s3_vld_q) begin
      rot_q <= rot_d;
    end
  end

endmodule

FILE: src/qvr_round.sv
// Output stage: rounds half up, drops the fraction bits and saturates each axis.
// Holds the output register of the block; depends on qvr_pkg.
module qvr_round #(
  parameter int W = 16,
  parameter int F = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic signed [3*W+3:0] rot_i [qvr_pkg::NUM_AXES],
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic signed [W-1:0]   rot_o [qvr_pkg::NUM_AXES],
  output logic                  sat_o
);
  import qvr_pkg::*;

  localparam int RW = 3 * W + 4;
  localparam int SW = RW + 1;
  localparam int EW = SW + 2 * F;
  localparam logic signed [EW-1:0] HALF    = EW'(1) << (2 * F - 1);
  localparam logic signed [W-1:0]  OUT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  OUT_MIN = {1'b1, {(W-1){1'b0}}};

  logic                out_vld_q;
  logic signed [W-1:0] rot_d [NUM_AXES];
  logic signed [W-1:0] rot_q [NUM_AXES];
  logic                sat_d;
  logic                sat_q;

  assign ready_o = !out_vld_q || ready_i;
  assign valid_o = out_vld_q;
  assign rot_o   = rot_q;
  assign sat_o   = sat_q;

  always_comb begin
    logic signed [EW-1:0] sum;
    logic        [SW-1:0] shf;
    logic      [SW-W:0]   top;
    logic                 ovf;
    sat_d = 1'b0;
    for (int k = 0; k < NUM_AXES; k++) begin
      sum = EW'(rot_i[k]) + HALF;
      shf = sum[EW-1:2*F];
      top = shf[SW-1:W-1];
      ovf = !((&top) || !(|top));
      if (ovf) begin
        rot_d[k] = shf[SW-1] ? OUT_MIN : OUT_MAX;
        sat_d    = 1'b1;
      end else begin
        rot_d[k] = shf[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ready_o) begin
      out_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rot_q <= rot_d;
      sat_q <= sat_d;
    end
  end

endmodule

FILE: src/quaternion_vector_rotate_unit.sv
// Quaternion vector rotation unit: returns the vector part of q * (0, v) * conj(q), the
// rotation of v by q, rounded half up from 2*QUAT_FRAC_BITS fraction bits and saturated to
// COMPONENT_WIDTH bits. It takes one transaction per clock cycle while the output is not
// stalled. A transaction passes through two stages for the first Hamilton product (products,
// then sums), two for the second, and one for rounding and saturation, which is also the
// output register. Every stage has its own valid bit and is loaded whenever it is empty or its
// successor takes its content, so up to five transactions are in flight and bubbles close up
// under output stalls. The quaternion is not normalized; the result scales with |q|^2.
module quaternion_vector_rotate_unit #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int QUAT_FRAC_BITS  = 14
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  qvr_in_if.sink   in_i,
  qvr_out_if.source out_o
);
  import qvr_pkg::*;

  localparam int W  = COMPONENT_WIDTH;
  localparam int AW = 2 * W + 2;
  localparam int RW = 3 * W + 4;
  localparam logic signed [W-1:0] OUT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] OUT_MIN = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0]  quat_in [NUM_PARTS];
  logic signed [W-1:0]  vec_in  [NUM_AXES];

  logic                 crs_vld;
  logic                 crs_rdy;
  logic signed [W-1:0]  crs_quat [NUM_PARTS];
  logic signed [AW-1:0] crs_part [NUM_PARTS];

  logic                 rot_vld;
  logic                 rot_rdy;
  logic signed [RW-1:0] rot_full [NUM_AXES];

  logic signed [W-1:0]  rot_out [NUM_AXES];

  assign quat_in[PART_W] = in_i.quat_w;
  assign quat_in[PART_X] = in_i.quat_x;
  assign quat_in[PART_Y] = in_i.quat_y;
  assign quat_in[PART_Z] = in_i.quat_z;
  assign vec_in[AXIS_X]  = in_i.vec_x;
  assign vec_in[AXIS_Y]  = in_i.vec_y;
  assign vec_in[AXIS_Z]  = in_i.vec_z;

  qvr_cross #(
    .W (W)
  ) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .quat_i  (quat_in),
    .vec_i   (vec_in),
    .valid_o (crs_vld),
    .ready_i (crs_rdy),
    .quat_o  (crs_quat),
    .part_o  (crs_part)
  );

  qvr_rotate #(
    .W (W)
  ) u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (crs_vld),
    .ready_o (crs_rdy),
    .quat_i  (crs_quat),
    .part_i  (crs_part),
    .valid_o (rot_vld),
    .ready_i (rot_rdy),
    .rot_o   (rot_full)
  );

  qvr_round #(
    .W (W),
    .F (QUAT_FRAC_BITS)
  ) u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_vld),
    .ready_o (rot_rdy),
    .rot_i   (rot_full),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .rot_o   (rot_out),
    .sat_o   (out_o.saturated)
  );

  assign out_o.rot_x = rot_out[AXIS_X];
  assign out_o.rot_y = rot_out[AXIS_Y];
  assign out_o.rot_z = rot_out[AXIS_Z];

  // A saturated transaction has at least one axis at a range limit.
  a_sat_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.saturated) |->
    (out_o.rot_x == OUT_MAX || out_o.rot_x == OUT_MIN ||
     out_o.rot_y == OUT_MAX || out_o.rot_y == OUT_MIN ||
     out_o.rot_z == OUT_MAX || out_o.rot_z == OUT_MIN))
    else $error("saturation flagged without a clipped axis");

  // The input is only refused when the whole pipeline is full behind a stalled output.
  a_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready && crs_vld && rot_vld))
    else $error("input refused while the pipeline has room");

  // A stalled result stays presented in the next cycle.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid)
    else $error("result dropped while stalled");

endmodule
